// ===== hdl/wps_pkg.sv =====
// shared constants, waypoint record type and helpers for the waypoint pose sequencer
`default_nettype none

package wps_pkg;

    // table geometry
    localparam int MAX_SHOTS = 16;
    localparam int IDX_W     = $clog2(MAX_SHOTS);
    localparam int CNT_W     = $clog2(MAX_SHOTS + 1);

    // q1.16 fraction, saturated at one
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;
    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

    // travel time after reset: 5 s in q16.16
    localparam logic [31:0] TRAVEL_TIME_RST = 32'd327680;

    // item commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    // pose components, in the order they are stepped
    localparam int POSE_N = 5;
    localparam int COMP_W = $clog2(POSE_N);
    localparam logic [COMP_W-1:0] COMP_PITCH = COMP_W'(0);
    localparam logic [COMP_W-1:0] COMP_YAW   = COMP_W'(1);
    localparam logic [COMP_W-1:0] COMP_X     = COMP_W'(2);
    localparam logic [COMP_W-1:0] COMP_Y     = COMP_W'(3);
    localparam logic [COMP_W-1:0] COMP_Z     = COMP_W'(4);
    localparam logic [COMP_W-1:0] COMP_LAST  = COMP_Z;

    // one waypoint as held in the table
    typedef struct packed {
        logic [31:0] pitch;
        logic [31:0] yaw;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] dwell;
    } wp_t;

    localparam int WP_W = $bits(wp_t);

    // pick one pose component of a waypoint
    function automatic logic [31:0] wp_comp(input wp_t w, input logic [COMP_W-1:0] k);
        logic [31:0] r;
        r = '0;
        unique case (k)
            COMP_PITCH: r = w.pitch;
            COMP_YAW:   r = w.yaw;
            COMP_X:     r = w.x;
            COMP_Y:     r = w.y;
            COMP_Z:     r = w.z;
            default:    r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/wps_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none

module wps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, data holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wps_div.sv =====
// serial divider giving the saturated q1.16 fraction timer / travel_time
`default_nettype none

module wps_div
    import wps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [31:0]       dividend,
    input  logic [31:0]       divisor,
    output logic              done,
    output logic [FRAC_W-1:0] quot
);

    localparam int STEP_W = $clog2(FRAC_BITS + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [31:0]       rem_reg;
    logic [FRAC_W-1:0] quot_reg;
    logic [32:0]       rem_shift;
    logic              fits;

    // one quotient bit per cycle
    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = rem_shift >= {1'b0, divisor};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // timer at or past travel time (or zero travel time) saturates at one
                if (dividend >= divisor)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    step_reg <= STEP_W'(FRAC_BITS);
                end
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            quot_reg <= (dividend >= divisor) ? FRAC_ONE : '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? 32'(rem_shift - {1'b0, divisor}) : rem_shift[31:0];
            quot_reg <= {quot_reg[FRAC_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== hdl/waypoint_pose_sequencer.sv =====
// waypoint pose sequencer: table of waypoints and a camera pose stepped toward them
//
// Input channel in_valid/in_ready carries one item: cmd selects an append (the
// waypoint fields) or a time tick (dt, toggle_pause). Every item gives exactly one
// result on out_valid/out_ready: the pose after the step, the targeted index, the
// paused flag and a flag for an append that found the table full.
// An append or a paused tick goes straight from acceptance to the result state.
// A running tick reads the target from the waypoint ram and, if the pose has
// arrived, then finishes. A moving tick also runs the serial divider (one
// quotient bit per cycle) and then steps the five components on one shared
// multiplier, a multiply and an add each. Items are taken one at a time; the next
// item is accepted while a finished result waits in the output register, and work
// stops in front of that register while the receiver stalls. The user must write
// travel_time through cfg_we/cfg_wdata only while the block is idle; the block
// itself does not enforce this.
// Reset empties the table to the single waypoint at the origin, clears pose, timer
// and index, restores travel time to 5 s and starts paused.
`default_nettype none

module waypoint_pose_sequencer
    import wps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [31:0]        dt,
    input  logic               toggle_pause,
    input  logic signed [31:0] new_pitch,
    input  logic signed [31:0] new_yaw,
    input  logic signed [31:0] new_x,
    input  logic signed [31:0] new_y,
    input  logic signed [31:0] new_z,
    input  logic [31:0]        new_dwell,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] cam_pitch,
    output logic signed [31:0] cam_yaw,
    output logic signed [31:0] cam_x,
    output logic signed [31:0] cam_y,
    output logic signed [31:0] cam_z,
    output logic [3:0]         shot_index,
    output logic               is_paused,
    output logic               add_dropped,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_MUL,
        S_ADD,
        S_ARRIVE,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   shot_count_reg;
    logic [IDX_W-1:0]   cur_index_reg;
    logic [31:0]        timer_reg;
    logic [31:0]        pose_reg [POSE_N];
    logic               paused_reg;
    logic               dropped_reg;
    logic [31:0]        travel_time_reg;
    logic [COMP_W-1:0]  comp_reg;
    logic signed [50:0] prod_reg;
    logic               out_valid_reg;

    logic [31:0]        out_pose_reg [POSE_N];
    logic [IDX_W-1:0]   out_index_reg;
    logic               out_paused_reg;
    logic               out_dropped_reg;

    logic               accept;
    logic               paused_new;
    logic               ram_we;
    logic               ram_re;
    logic [WP_W-1:0]    ram_rdata;
    wp_t                new_wp;
    wp_t                tgt;
    logic               at_tgt;
    logic [32:0]        timer_sum;
    logic [CNT_W-1:0]   idx_inc;
    logic [31:0]        pose_a;
    logic [31:0]        tgt_b;
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic [31:0]        pose_new;
    logic               out_load;
    logic               div_start;
    logic               div_done;
    logic [FRAC_W-1:0]  frac;

    // handshake
    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign paused_new = paused_reg ^ toggle_pause;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // waypoint table: appends write, running ticks read the target
    assign new_wp = '{pitch: new_pitch, yaw: new_yaw, x: new_x, y: new_y, z: new_z,
                      dwell: new_dwell};
    assign ram_we = accept && (cmd == CMD_ADD) &&
                    (shot_count_reg < CNT_W'(MAX_SHOTS));
    assign ram_re = accept && (cmd == CMD_TICK) && !paused_new;

    wps_ram #(
        .WIDTH (WP_W),
        .DEPTH (MAX_SHOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (shot_count_reg[IDX_W-1:0]),
        .wdata (new_wp),
        .re    (ram_re),
        .raddr (cur_index_reg),
        .rdata (ram_rdata)
    );

    // entry 0 is the origin waypoint and is never appended to
    assign tgt    = (cur_index_reg == '0) ? wp_t'('0) : wp_t'(ram_rdata);
    assign at_tgt = (pose_reg[COMP_X] == tgt.x) && (pose_reg[COMP_Y] == tgt.y) &&
                    (pose_reg[COMP_Z] == tgt.z);

    // saturating timer update
    assign timer_sum = {1'b0, timer_reg} + {1'b0, dt};

    // next waypoint with wraparound
    assign idx_inc = CNT_W'(cur_index_reg) + CNT_W'(1);

    // fraction of the way, serial divide
    assign div_start = (state_reg == S_CHECK) && !at_tgt;

    wps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (timer_reg),
        .divisor  (travel_time_reg),
        .done     (div_done),
        .quot     (frac)
    );

    // shared step datapath: diff * frac, then a + floor(prod / 2^16)
    assign pose_a   = pose_reg[comp_reg];
    assign tgt_b    = wp_comp(tgt, comp_reg);
    assign diff     = $signed({tgt_b[31], tgt_b}) - $signed({pose_a[31], pose_a});
    assign prod     = diff * $signed({1'b0, frac});
    assign pose_new = pose_a + prod_reg[FRAC_BITS+31:FRAC_BITS];

    // control, state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            shot_count_reg  <= CNT_W'(1);
            cur_index_reg   <= '0;
            timer_reg       <= '0;
            paused_reg      <= 1'b1;
            dropped_reg     <= 1'b0;
            travel_time_reg <= TRAVEL_TIME_RST;
            comp_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_index_reg   <= '0;
            out_paused_reg  <= 1'b0;
            out_dropped_reg <= 1'b0;
            for (int k = 0; k < POSE_N; k++)
            begin
                pose_reg[k]     <= '0;
                out_pose_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                travel_time_reg <= cfg_wdata;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                for (int k = 0; k < POSE_N; k++)
                begin
                    out_pose_reg[k] <= pose_reg[k];
                end
                out_index_reg   <= cur_index_reg;
                out_paused_reg  <= paused_reg;
                out_dropped_reg <= dropped_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        dropped_reg <= 1'b0;
                        if (cmd == CMD_ADD)
                        begin
                            if (ram_we)
                            begin
                                shot_count_reg <= shot_count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                dropped_reg <= 1'b1;
                            end
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            paused_reg <= paused_new;
                            if (paused_new)
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                timer_reg <= timer_sum[32] ? '1 : timer_sum[31:0];
                                state_reg <= S_CHECK;
                            end
                        end
                    end
                end

                S_CHECK:
                begin
                    if (at_tgt)
                    begin
                        // dwell over: advance to the next waypoint
                        if (timer_reg > tgt.dwell)
                        begin
                            if ((idx_inc >= shot_count_reg) ||
                                (idx_inc >= CNT_W'(MAX_SHOTS)))
                            begin
                                cur_index_reg <= '0;
                            end
                            else
                            begin
                                cur_index_reg <= idx_inc[IDX_W-1:0];
                            end
                            timer_reg <= '0;
                        end
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        comp_reg  <= COMP_PITCH;
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    state_reg <= S_ADD;
                end

                S_ADD:
                begin
                    pose_reg[comp_reg] <= pose_new;
                    if (comp_reg == COMP_LAST)
                    begin
                        state_reg <= S_ARRIVE;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + COMP_W'(1);
                        state_reg <= S_MUL;
                    end
                end

                S_ARRIVE:
                begin
                    if (at_tgt)
                    begin
                        timer_reg <= '0;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // product register of the shared multiplier
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            prod_reg <= prod;
        end
    end

    // outputs
    assign out_valid   = out_valid_reg;
    assign cam_pitch   = out_pose_reg[COMP_PITCH];
    assign cam_yaw     = out_pose_reg[COMP_YAW];
    assign cam_x       = out_pose_reg[COMP_X];
    assign cam_y       = out_pose_reg[COMP_Y];
    assign cam_z       = out_pose_reg[COMP_Z];
    assign shot_index  = 4'(out_index_reg);
    assign is_paused   = out_paused_reg;
    assign add_dropped = out_dropped_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for the waypoint pose sequencer
`timescale 1ns / 1ps

module tb;
    import wps_pkg::*;

    // one item as offered on the input channel
    typedef struct packed {
        logic        cmd;
        logic [31:0] dt;
        logic        toggle;
        wp_t         wp;
    } pose_cmd_t;

    // one result: pose after the step and the flags
    typedef struct packed {
        logic [31:0] pitch;
        logic [31:0] yaw;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [3:0]  idx;
        logic        paused;
        logic        dropped;
    } pose_res_t;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_LEN    = 300;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               cmd = CMD_TICK;
    logic [31:0]        dt = '0;
    logic               toggle_pause = 1'b0;
    logic signed [31:0] new_pitch = '0;
    logic signed [31:0] new_yaw = '0;
    logic signed [31:0] new_x = '0;
    logic signed [31:0] new_y = '0;
    logic signed [31:0] new_z = '0;
    logic [31:0]        new_dwell = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] cam_pitch;
    logic signed [31:0] cam_yaw;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic [3:0]         shot_index;
    logic               is_paused;
    logic               add_dropped;
    logic               cfg_we = 1'b0;
    logic [31:0]        cfg_wdata = '0;

    // predictor state
    wp_t         table_wp [MAX_SHOTS];
    int unsigned n_shots;
    int unsigned tgt_idx;
    logic [31:0] dwell_time;
    wp_t         pose;
    bit          paused;
    logic [31:0] travel_len;

    pose_cmd_t pending_items [$];
    pose_res_t expected_poses [$];
    pose_cmd_t on_port;
    pose_res_t want_pose;
    int        n_errors = 0;
    int        items_in = 0;
    int        results_seen = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    int        stall_cycles = 0;
    logic      quiet;

    // no idling on either side over a long stretch of the run
    assign quiet = (items_in >= 300) && (items_in < 380);

    waypoint_pose_sequencer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .dt           (dt),
        .toggle_pause (toggle_pause),
        .new_pitch    (new_pitch),
        .new_yaw      (new_yaw),
        .new_x        (new_x),
        .new_y        (new_y),
        .new_z        (new_z),
        .new_dwell    (new_dwell),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cam_pitch    (cam_pitch),
        .cam_yaw      (cam_yaw),
        .cam_x        (cam_x),
        .cam_y        (cam_y),
        .cam_z        (cam_z),
        .shot_index   (shot_index),
        .is_paused    (is_paused),
        .add_dropped  (add_dropped),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // one pose component moved toward its target by the fraction t, floor toward minus infinity
    function automatic logic [31:0] step_toward(logic [31:0] from, logic [31:0] to,
                                                logic [FRAC_W-1:0] t);
        longint diff;
        longint prod;
        diff = longint'($signed(to)) - longint'($signed(from));
        prod = diff * longint'(t);
        return 32'(longint'($signed(from)) + (prod >>> FRAC_BITS));
    endfunction

    // arrival is decided by position only
    function automatic bit at_target(int unsigned i);
        return pose.x == table_wp[i].x && pose.y == table_wp[i].y && pose.z == table_wp[i].z;
    endfunction

    // apply one item to the predictor and return the result it gives
    function automatic pose_res_t advance_sequencer(pose_cmd_t c);
        pose_res_t         r;
        logic [32:0]       sum;
        logic [63:0]       quo;
        logic [FRAC_W-1:0] frac;
        int unsigned       i;
        r.dropped = 1'b0;
        if (c.cmd == CMD_ADD)
        begin
            if (n_shots < MAX_SHOTS)
            begin
                table_wp[n_shots] = c.wp;
                n_shots++;
            end
            else
            begin
                r.dropped = 1'b1;
            end
        end
        else
        begin
            if (c.toggle)
                paused = !paused;
            if (!paused)
            begin
                sum = {1'b0, dwell_time} + {1'b0, c.dt};
                dwell_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                i = tgt_idx;
                if (at_target(i))
                begin
                    // hold at the waypoint until the dwell has passed
                    if (dwell_time > table_wp[i].dwell)
                    begin
                        i++;
                        if (i >= n_shots)
                            i = 0;
                        tgt_idx = i;
                        dwell_time = '0;
                    end
                end
                else
                begin
                    // fraction of travel done, saturated at one
                    if (travel_len == '0)
                    begin
                        frac = FRAC_ONE;
                    end
                    else
                    begin
                        quo = {16'b0, dwell_time, 16'b0} / {32'b0, travel_len};
                        frac = (quo > 64'(FRAC_ONE)) ? FRAC_ONE : quo[FRAC_W-1:0];
                    end
                    pose.pitch = step_toward(pose.pitch, table_wp[i].pitch, frac);
                    pose.yaw   = step_toward(pose.yaw, table_wp[i].yaw, frac);
                    pose.x     = step_toward(pose.x, table_wp[i].x, frac);
                    pose.y     = step_toward(pose.y, table_wp[i].y, frac);
                    pose.z     = step_toward(pose.z, table_wp[i].z, frac);
                    if (at_target(i))
                        dwell_time = '0;
                end
            end
        end
        r.pitch  = pose.pitch;
        r.yaw    = pose.yaw;
        r.x      = pose.x;
        r.y      = pose.y;
        r.z      = pose.z;
        r.idx    = 4'(tgt_idx);
        r.paused = paused;
        return r;
    endfunction

    task automatic flag_error(string msg);
        $display("tb: %s", msg);
        n_errors++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s: got %h, want %h", results_seen, name, got, want));
    endtask

    task automatic queue_tick(logic [31:0] d, logic tog);
        pose_cmd_t c;
        c.cmd    = CMD_TICK;
        c.dt     = d;
        c.toggle = tog;
        c.wp     = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        pending_items.push_back(c);
    endtask

    task automatic queue_add(wp_t w);
        pose_cmd_t c;
        c.cmd    = CMD_ADD;
        c.dt     = $urandom();
        c.toggle = 1'($urandom_range(1));
        c.wp     = w;
        pending_items.push_back(c);
    endtask

    // random mix: mostly ticks of varied length, a few pause flips, appends that are dropped
    task automatic queue_random(int n);
        pose_cmd_t c;
        int        k;
        int        pick;
        for (k = 0; k < n; k++)
        begin
            pick     = $urandom_range(99);
            c.cmd    = (pick < 10) ? CMD_ADD : CMD_TICK;
            c.toggle = ($urandom_range(99) < 5);
            c.wp     = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            pick     = $urandom_range(99);
            if (pick < 40)
                c.dt = $urandom_range(4096);
            else if (pick < 70)
                c.dt = $urandom_range(32'h0008_0000);
            else if (pick < 85)
                c.dt = $urandom_range(32'h0100_0000);
            else
                c.dt = $urandom();
            pending_items.push_back(c);
        end
    endtask

    // sender pauses until every expected result has come
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_poses.size() != 0);
    endtask

    task automatic write_travel(logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        travel_len = v;
    endtask

    // stimulus and phases
    initial
    begin
        wp_t w;
        int  k;
        for (k = 0; k < MAX_SHOTS; k++)
            table_wp[k] = '0;
        n_shots    = 1;
        tgt_idx    = 0;
        dwell_time = '0;
        pose       = '0;
        paused     = 1'b1;
        travel_len = TRAVEL_TIME_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // paused after reset: tick holds everything
        queue_tick(32'hFFFF_FFFF, 1'b0);
        // resume at the origin, timer not past zero dwell yet
        queue_tick(32'd0, 1'b1);
        // single waypoint: advance wraps back to index 0
        queue_tick(32'd1, 1'b0);
        // waypoint order: pitch, yaw, x, y, z, dwell
        w = {32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0};
        queue_add(w);
        // advance to the new waypoint, a partial move, then saturated timer lands on the target
        queue_tick(32'h0001_0000, 1'b0);
        queue_tick(32'h0002_8000, 1'b0);
        queue_tick(32'hFFFF_FFFF, 1'b0);
        // pause and resume around a tick
        queue_tick(32'd0, 1'b1);
        queue_tick(32'd123, 1'b1);
        w = {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFE};
        queue_add(w);
        // fill the table, first filler back at the origin
        for (k = 0; k < 13; k++)
        begin
            w = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
            w.dwell = $urandom_range(32'h0004_0000);
            if (k == 0)
            begin
                w.x = '0;
                w.y = '0;
                w.z = '0;
            end
            queue_add(w);
        end
        // table full: dropped
        w = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        queue_add(w);

        queue_random(60);
        wait_drained();
        write_travel(32'd1);
        queue_random(70);
        wait_drained();
        write_travel(32'hFFFF_FFFF);
        queue_random(80);
        wait_drained();
        // zero travel time jumps straight to the target
        write_travel(32'd0);
        queue_random(60);
        wait_drained();
        write_travel($urandom_range(32'h0000_4000, 32'h0040_0000));
        queue_random(90);
        wait_drained();
        write_travel(TRAVEL_TIME_RST >> 2);
        queue_random(90);
        wait_drained();

        repeat (64) @(posedge clk);
        if (n_errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_poses.push_back(advance_sequencer(on_port));
                items_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= 7))
                begin
                    on_port = pending_items.pop_front();
                    in_valid     <= 1'b1;
                    cmd          <= on_port.cmd;
                    dt           <= on_port.dt;
                    toggle_pause <= on_port.toggle;
                    new_pitch    <= on_port.wp.pitch;
                    new_yaw      <= on_port.wp.yaw;
                    new_x        <= on_port.wp.x;
                    new_y        <= on_port.wp.y;
                    new_z        <= on_port.wp.z;
                    new_dwell    <= on_port.wp.dwell;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_poses.size() == 0)
                begin
                    flag_error($sformatf("result %0d with nothing expected", results_seen));
                end
                else
                begin
                    want_pose = expected_poses.pop_front();
                    compare_field("cam_pitch", cam_pitch, want_pose.pitch);
                    compare_field("cam_yaw", cam_yaw, want_pose.yaw);
                    compare_field("cam_x", cam_x, want_pose.x);
                    compare_field("cam_y", cam_y, want_pose.y);
                    compare_field("cam_z", cam_z, want_pose.z);
                    compare_field("shot_index", 32'(shot_index), 32'(want_pose.idx));
                    compare_field("is_paused", 32'(is_paused), 32'(want_pose.paused));
                    compare_field("add_dropped", 32'(add_dropped), 32'(want_pose.dropped));
                end
            end
            // one long hold-off so the block backs up to its input
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && results_seen == HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= quiet || ($urandom_range(99) >= 7);
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
